// ===== src/dirty_bitmap_range_coalescer_top_defines.svh =====
// assertion macros used by the checker in drc_checker.sv
// no dependencies; expects clk and arst_n in scope where used
`ifndef DIRTY_BITMAP_RANGE_COALESCER_TOP_DEFINES_SVH
`define DIRTY_BITMAP_RANGE_COALESCER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drc assertion failed");

// next-cycle implication, disabled during reset
`define DRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drc assertion failed");

`endif

// ===== src/drc_pkg.sv =====
// types, constants and helper functions for the dirty bitmap range coalescer
// no dependencies
`default_nettype none
package drc_pkg;
	localparam int MAX_WORDS = 16;
	localparam int SEGMENT_BITS = 8;
	localparam int WORD_BITS = 64;
	localparam int NSEG = WORD_BITS / SEGMENT_BITS;
	localparam int POS_W = $clog2(MAX_WORDS + 1);
	localparam int START_W = 10;
	localparam int LEN_W = 11;
	localparam int CNT_W = 11;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 21;
	localparam logic [SEGMENT_BITS-1:0] SEG_MASK = 8'hff;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IO_COST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BYTES = 2'd3;

	typedef struct packed {
		logic [63:0] bitmap_word;
		logic        final_word;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  range_start;
		logic [10:0] range_blocks;
		logic        has_range;
		logic        end_of_bitmap;
		logic [10:0] ranges_total;
	} out_item_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic [WORD_BITS-1:0] mask;
		logic [START_W-1:0]   base;
		logic                 fin;
	} qentry_t;

	typedef struct packed {
		logic [10:0] max_ranges;
		logic [16:0] block_bytes;
		logic [20:0] io_cost_bytes;
		logic [19:0] segment_bytes;
	} cfg_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) c = c + {3'b000, v[i]};
		return c;
	endfunction

	// index of lowest set bit, WORD_BITS when none
	function automatic logic [6:0] tz65(input logic [WORD_BITS:0] v);
		logic [6:0] r;
		r = 7'(WORD_BITS);
		for (int i = WORD_BITS; i >= 0; i--) begin
			if (v[i]) r = 7'(i);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/dirty_bitmap_range_coalescer_top.sv =====
// top level of the dirty bitmap range coalescer: config registers, front, queue, back
// depends on drc_pkg, drc_front, drc_queue, drc_back
//
// channel  | handshake          | payload
// in       | in_valid/in_ready  | in_data   (bitmap_word, final_word)
// out      | out_valid/out_ready| out_data  (range_start .. ranges_total)
// cfg      | cfg_we             | cfg_index, cfg_wdata
//
// a word is classified and queued in the cycle it is accepted (queue of four words)
// the back end walks the runs of set bits in the classified word one by one, then closes
// the word; while closing, the end item of a bitmap leaves and the next word is taken
// the run walker in the back end sets the rate
// reset clears position, pending range, count and queue; config returns to defaults
// input stalls only when the queue is full, the back end only on a full output register
`default_nettype none
module dirty_bitmap_range_coalescer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire drc_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output drc_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_we,
	input  wire logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [drc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	drc_pkg::cfg_t cfg_q;
	drc_pkg::qentry_t entry, head;
	logic q_empty, q_full, q_pop, take;

	assign in_ready = !q_full;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_ranges <= 11'd513;
			cfg_q.block_bytes <= 17'd4096;
			cfg_q.io_cost_bytes <= 21'd16384;
			cfg_q.segment_bytes <= 20'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				drc_pkg::REG_MAX_RANGES: cfg_q.max_ranges <= cfg_wdata[10:0];
				drc_pkg::REG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_wdata[16:0];
				drc_pkg::REG_IO_COST: cfg_q.io_cost_bytes <= cfg_wdata[20:0];
				drc_pkg::REG_SEGMENT_BYTES: cfg_q.segment_bytes <= cfg_wdata[19:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	drc_front u_front (
		.clk(clk), .arst_n(arst_n), .item(in_data), .take(take), .cfg(cfg_q), .entry(entry)
	);

	drc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(take), .wdata(entry), .pop(q_pop),
		.head(head), .empty(q_empty), .full(q_full)
	);

	drc_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .q_pop(q_pop),
		.max_ranges(cfg_q.max_ranges), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);
endmodule
`default_nettype wire

// ===== src/drc_front.sv =====
// front: classifies each segment of a word as dense or sparse, tracks word position
// depends on drc_pkg
`default_nettype none
module drc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire drc_pkg::in_item_t item,
	input  wire logic             take,
	input  wire drc_pkg::cfg_t    cfg,
	output drc_pkg::qentry_t      entry
);
	logic [drc_pkg::POS_W-1:0] pos_q;
	logic [drc_pkg::WORD_BITS-1:0] mask;

	always_comb begin
		logic [7:0]  bits;
		logic [3:0]  ones;
		logic [2:0]  runs;
		logic [21:0] c_blk;
		logic [23:0] c_io;
		logic [24:0] cost;
		mask = '0;
		for (int s = 0; s < drc_pkg::NSEG; s++) begin
			bits = item.bitmap_word[s*drc_pkg::SEGMENT_BITS +: drc_pkg::SEGMENT_BITS];
			ones = drc_pkg::pop8(bits);
			runs = 3'(drc_pkg::pop8(bits & ~(bits << 1) & drc_pkg::SEG_MASK));
			c_blk = 22'(ones) * 22'(cfg.block_bytes);
			c_io = 24'(runs - 3'd1) * 24'(cfg.io_cost_bytes);
			cost = 25'(c_blk) + 25'(c_io);
			// dense segment collapses to one whole-segment run
			if (bits != '0 && cost >= 25'(cfg.segment_bytes))
				mask[s*drc_pkg::SEGMENT_BITS +: drc_pkg::SEGMENT_BITS] = drc_pkg::SEG_MASK;
			else
				mask[s*drc_pkg::SEGMENT_BITS +: drc_pkg::SEGMENT_BITS] = bits;
		end
		// words beyond the bitmap size contribute nothing
		if (pos_q >= drc_pkg::POS_W'(drc_pkg::MAX_WORDS)) mask = '0;
	end

	assign entry.mask = mask;
	assign entry.base = drc_pkg::START_W'(pos_q) << $clog2(drc_pkg::WORD_BITS);
	assign entry.fin = item.final_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (item.final_word)
				pos_q <= '0;
			else if (pos_q < drc_pkg::POS_W'(drc_pkg::MAX_WORDS))
				pos_q <= pos_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== src/drc_queue.sv =====
// short queue of classified words between front and back
// depends on drc_pkg
`default_nettype none
module drc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire drc_pkg::qentry_t  wdata,
	input  wire logic              pop,
	output drc_pkg::qentry_t       head,
	output logic                   empty,
	output logic                   full
);
	drc_pkg::qentry_t mem_q [drc_pkg::QDEPTH];
	logic [drc_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [drc_pkg::QCNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == drc_pkg::QCNT_W'(drc_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/drc_back.sv =====
// back: walks the runs of each classified word, merges, limits and emits ranges
// depends on drc_pkg
`default_nettype none
module drc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire drc_pkg::qentry_t  head,
	input  wire logic              q_empty,
	output logic                   q_pop,
	input  wire logic [10:0]       max_ranges,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output drc_pkg::out_item_t     out_data
);
	logic cur_valid_q, fin_q;
	logic [drc_pkg::WORD_BITS-1:0] rem_q;
	logic [drc_pkg::START_W-1:0] base_q;
	logic [drc_pkg::START_W-1:0] pstart_q;
	logic [drc_pkg::LEN_W-1:0] plen_q;
	logic pvalid_q;
	logic [drc_pkg::CNT_W-1:0] kept_q;
	logic out_valid_q;
	drc_pkg::out_item_t out_q;

	logic [drc_pkg::WORD_BITS-1:0] low, rest;
	logic [drc_pkg::WORD_BITS:0] t;
	logic [6:0] st, en, len;
	logic [drc_pkg::START_W-1:0] abs_start;
	logic [11:0] pend_end;
	logic has_run, merge, out_free, done;

	assign low = rem_q & (~rem_q + 1'b1);
	assign t = {1'b0, rem_q} + {1'b0, low};
	assign rest = rem_q & t[drc_pkg::WORD_BITS-1:0];
	assign st = drc_pkg::tz65({1'b0, rem_q});
	assign en = drc_pkg::tz65(t);
	assign len = en - st;
	assign abs_start = base_q + drc_pkg::START_W'(st);
	assign pend_end = 12'(pstart_q) + 12'(plen_q);
	assign has_run = cur_valid_q && (rem_q != '0);
	assign merge = pvalid_q && (pend_end == 12'(abs_start));
	assign out_free = !out_valid_q || out_ready;
	// word finished: no runs left, and room for the end item if this was the last word
	assign done = cur_valid_q && (rem_q == '0) && (!fin_q || out_free);
	assign q_pop = (!cur_valid_q || done) && !q_empty;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			fin_q <= 1'b0;
			rem_q <= '0;
			base_q <= '0;
			pstart_q <= '0;
			plen_q <= '0;
			pvalid_q <= 1'b0;
			kept_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			if (has_run) begin
				if (merge) begin
					plen_q <= plen_q + drc_pkg::LEN_W'(len);
					rem_q <= rest;
				end else if (!pvalid_q || out_free) begin
					if (pvalid_q) begin
						out_valid_q <= 1'b1;
						out_q <= '{range_start: pstart_q, range_blocks: plen_q,
							has_range: 1'b1, end_of_bitmap: 1'b0, ranges_total: '0};
					end
					if (kept_q < max_ranges) begin
						pstart_q <= abs_start;
						plen_q <= drc_pkg::LEN_W'(len);
						pvalid_q <= 1'b1;
						kept_q <= kept_q + 1'b1;
					end else begin
						pvalid_q <= 1'b0;
					end
					rem_q <= rest;
				end
			end else if (done && fin_q) begin
				out_valid_q <= 1'b1;
				if (pvalid_q)
					out_q <= '{range_start: pstart_q, range_blocks: plen_q,
						has_range: 1'b1, end_of_bitmap: 1'b1, ranges_total: kept_q};
				else
					out_q <= '{range_start: '0, range_blocks: '0,
						has_range: 1'b0, end_of_bitmap: 1'b1, ranges_total: kept_q};
				pstart_q <= '0;
				plen_q <= '0;
				pvalid_q <= 1'b0;
				kept_q <= '0;
			end

			if (q_pop) begin
				cur_valid_q <= 1'b1;
				rem_q <= head.mask;
				base_q <= head.base;
				fin_q <= head.fin;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/drc_checker.sv =====
// port-level checks for the range coalescer, bound to the top level
// depends on drc_pkg and dirty_bitmap_range_coalescer_top_defines.svh
`default_nettype none
`include "dirty_bitmap_range_coalescer_top_defines.svh"
module drc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire drc_pkg::out_item_t out_data
);
	// a stalled request holds
	`DRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// empty items carry no range
	`DRC_ASSERT_NOW(a_empty_item, out_valid && !out_data.has_range, out_data.end_of_bitmap && out_data.range_blocks == '0 && out_data.range_start == '0)
	// count only on the end item
	`DRC_ASSERT_NOW(a_total_end, out_valid && !out_data.end_of_bitmap, out_data.ranges_total == '0)
	// every real range has length
	`DRC_ASSERT_NOW(a_range_len, out_valid && out_data.has_range, out_data.range_blocks != '0)
endmodule

bind dirty_bitmap_range_coalescer_top drc_checker u_drc_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);
`default_nettype wire

// ===== bench/tb_dirty_bitmap_range_coalescer_top.sv =====
// testbench for the dirty bitmap range coalescer: directed and random bitmaps
// checked against an in-bench range predictor; depends on drc_pkg and the top level
`timescale 1ns / 100ps
`default_nettype none
module tb_dirty_bitmap_range_coalescer_top;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	drc_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	drc_pkg::out_item_t out_data;
	logic cfg_we;
	logic [drc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [drc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	dirty_bitmap_range_coalescer_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	// predictor state and configuration
	logic [10:0] lim_ranges;
	logic [16:0] blk_bytes;
	logic [20:0] io_cost;
	logic [19:0] seg_bytes;
	logic [31:0] pend_start;
	logic [31:0] pend_len;
	logic pend_valid;
	logic [31:0] kept;
	int word_pos;

	drc_pkg::out_item_t expected_ranges[$];
	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	int hold_cycles;
	bit timed_out;

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	function automatic void push_range(input logic [31:0] s, input logic [31:0] l,
			input logic has, input logic fin, input logic [31:0] tot);
		drc_pkg::out_item_t r;
		r.range_start = s[9:0];
		r.range_blocks = l[10:0];
		r.has_range = has;
		r.end_of_bitmap = fin;
		r.ranges_total = tot[10:0];
		expected_ranges.push_back(r);
	endfunction

	function automatic void merge_range(input logic [31:0] s, input logic [31:0] l);
		if (pend_valid && pend_start + pend_len == s) begin
			pend_len = pend_len + l;
			return;
		end
		if (pend_valid) begin
			push_range(pend_start, pend_len, 1'b1, 1'b0, 0);
			pend_valid = 1'b0;
		end
		if (kept < lim_ranges) begin
			pend_start = s;
			pend_len = l;
			pend_valid = 1'b1;
			kept++;
		end
	endfunction

	function automatic void predict_word(input drc_pkg::in_item_t it);
		logic [7:0] bits;
		logic [31:0] base;
		logic [63:0] cost;
		int ones;
		int runs;
		int first;
		int i;
		if (word_pos < drc_pkg::MAX_WORDS) begin
			for (int sg = 0; sg < 8; sg++) begin
				bits = it.bitmap_word[sg*8 +: 8];
				base = word_pos * 64 + sg * 8;
				if (bits == 8'h00) continue;
				ones = $countones(bits);
				runs = $countones(bits & ~(bits << 1));
				cost = 64'(ones) * blk_bytes + 64'(runs - 1) * io_cost;
				if (cost >= 64'(seg_bytes)) begin
					merge_range(base, 8);
					continue;
				end
				i = 0;
				while (i < 8) begin
					if (bits[i]) begin
						first = i;
						while (i + 1 < 8 && bits[i+1]) i++;
						merge_range(base + first, i - first + 1);
					end
					i++;
				end
			end
			word_pos++;
		end
		if (it.final_word) begin
			if (pend_valid) push_range(pend_start, pend_len, 1'b1, 1'b1, kept);
			else push_range(0, 0, 1'b0, 1'b1, kept);
			pend_start = 0;
			pend_len = 0;
			pend_valid = 1'b0;
			kept = 0;
			word_pos = 0;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		drc_pkg::out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_ranges.size() == 0) begin
				report_mismatch("unexpected result", out_data, 0);
			end else begin
				w = expected_ranges.pop_front();
				if (out_data.range_start !== w.range_start)
					report_mismatch("range_start", out_data.range_start, w.range_start);
				if (out_data.range_blocks !== w.range_blocks)
					report_mismatch("range_blocks", out_data.range_blocks, w.range_blocks);
				if (out_data.has_range !== w.has_range)
					report_mismatch("has_range", out_data.has_range, w.has_range);
				if (out_data.end_of_bitmap !== w.end_of_bitmap)
					report_mismatch("end_of_bitmap", out_data.end_of_bitmap,
						w.end_of_bitmap);
				if (out_data.ranges_total !== w.ranges_total)
					report_mismatch("ranges_total", out_data.ranges_total, w.ranges_total);
			end
		end
	end

	// receiver ready, with an optional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_hold) begin
			out_ready <= 1'b0;
			hold_cycles++;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with nothing accepted and no receiver hold
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || recv_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_word(input logic [63:0] w, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {w, fin};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_word({w, fin});
	endtask

	// drop valid after the last request of a burst
	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_ranges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [drc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v[drc_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			drc_pkg::REG_MAX_RANGES: lim_ranges = v[10:0];
			drc_pkg::REG_BLOCK_BYTES: blk_bytes = v[16:0];
			drc_pkg::REG_IO_COST: io_cost = v[20:0];
			drc_pkg::REG_SEGMENT_BYTES: seg_bytes = v[19:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(4))
			0: w = w & {$urandom, $urandom};
			1: w = w & {$urandom, $urandom} & {$urandom, $urandom};
			2: w = '1;
			3: w = w | {$urandom, $urandom};
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_bitmap(input int nwords);
		for (int i = 0; i < nwords; i++)
			send_word(rand_word(), i == nwords - 1);
		release_input();
	endtask

	task automatic test_directed();
		send_word(64'h0, 1'b1);
		send_word(64'hffff_ffff_ffff_ffff, 1'b1);
		send_word(64'h5555_5555_5555_5555, 1'b0);
		send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		send_word(64'h8000_0000_0000_0001, 1'b0);
		send_word(64'h0000_0000_0000_0001, 1'b0);
		send_word(64'h0, 1'b1);
		send_word(64'h0101_8080_1248_c3e7, 1'b1);
		// more words than the bitmap holds
		for (int i = 0; i < drc_pkg::MAX_WORDS + 2; i++)
			send_word(64'h8000_0000_0000_0001, i == drc_pkg::MAX_WORDS + 1);
		release_input();
		wait_drained();
	endtask

	task automatic test_config_extremes();
		write_reg(drc_pkg::REG_MAX_RANGES, 0);
		write_reg(drc_pkg::REG_BLOCK_BYTES, 512);
		write_reg(drc_pkg::REG_IO_COST, 0);
		write_reg(drc_pkg::REG_SEGMENT_BYTES, 4096);
		send_bitmap(3);
		wait_drained();
		write_reg(drc_pkg::REG_MAX_RANGES, 2);
		write_reg(drc_pkg::REG_IO_COST, 21'h1fffff);
		write_reg(drc_pkg::REG_SEGMENT_BYTES, 20'hfffff);
		send_bitmap(4);
		wait_drained();
		write_reg(drc_pkg::REG_MAX_RANGES, 11'h7ff);
		write_reg(drc_pkg::REG_BLOCK_BYTES, 17'h1ffff);
		write_reg(drc_pkg::REG_IO_COST, 1048576);
		write_reg(drc_pkg::REG_SEGMENT_BYTES, 524288);
		send_bitmap(5);
		wait_drained();
		write_reg(drc_pkg::REG_MAX_RANGES, 1024);
		write_reg(drc_pkg::REG_BLOCK_BYTES, 65536);
		write_reg(drc_pkg::REG_SEGMENT_BYTES, 20'h00001);
		send_bitmap(2);
		wait_drained();
	endtask

	task automatic test_random(input int nwords);
		int sent;
		sent = 0;
		while (sent < nwords) begin
			int n;
			n = $urandom_range(1, 5);
			if ($urandom_range(9) == 0) n = $urandom_range(16, 19);
			send_bitmap(n);
			sent += n;
		end
		wait_drained();
		write_reg(drc_pkg::REG_MAX_RANGES, $urandom_range(1, 40));
		write_reg(drc_pkg::REG_BLOCK_BYTES, $urandom_range(512, 65536));
		write_reg(drc_pkg::REG_IO_COST, $urandom_range(0, 1048576));
		write_reg(drc_pkg::REG_SEGMENT_BYTES, $urandom_range(4096, 524288));
	endtask

	task automatic test_backpressure();
		recv_hold = 1'b1;
		hold_cycles = 0;
		fork
			send_bitmap(10);
			begin
				while (hold_cycles < 300) @(posedge clk);
				recv_hold = 1'b0;
			end
		join
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		recv_hold = 1'b0;
		hold_cycles = 0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 9;
		recv_idle_pct = 84;
		lim_ranges = 11'd513;
		blk_bytes = 17'd4096;
		io_cost = 21'd16384;
		seg_bytes = 20'd32768;
		pend_start = 0;
		pend_len = 0;
		pend_valid = 1'b0;
		kept = 0;
		word_pos = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random(55);
		send_idle_pct = 84;
		recv_idle_pct = 9;
		test_random(55);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(55);
		test_backpressure();
		wait_drained();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
